// ----- hdl/lts_pkg.sv -----
// lts_pkg: types and constants for the linear tween slot table
// no dependencies
`default_nettype none
package lts_pkg;
	localparam int SLOT_COUNT_DEF = 16;
	localparam int FT_W = 20;

	typedef enum logic [2:0] {
		CMD_START     = 3'd0,
		CMD_TICK      = 3'd1,
		CMD_PAUSE_ONE = 3'd2,
		CMD_FREE_ONE  = 3'd3,
		CMD_PAUSE_ALL = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [2:0]         command;
		logic [15:0]        target_key;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
		logic [23:0]        length;
		logic [FT_W-1:0]    frame_time;
		logic               pause_value;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        out_key;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic               finished;
		logic               last;
	} out_item_t;

	// one slot entry as kept in the slot memory
	typedef struct packed {
		logic [15:0]        key;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [15:0] ex;
		logic signed [15:0] ey;
		logic [31:0]        elapsed;
		logic [23:0]        length;
	} slot_t;
endpackage
`default_nettype wire

// ----- hdl/linear_tween_slot_table.sv -----
// linear_tween_slot_table: top level, slot memory, sequencer, divider
// depends on lts_pkg
`default_nettype none
// The slot table keeps each slot's key, points, elapsed time and duration in a
// single synchronous memory with a registered read port. Valid and pause bits
// are flip-flops. Items are handled one at a time. Start, pause and pause-all
// pass through accept and one memory step. A free also passes evaluate and
// output and waits out any output stall. A tick walks the slots in order. A
// slot that completes passes read, evaluate, output and write-back. A slot that
// interpolates also runs a restoring divider (one quotient bit a cycle) for a
// 17-bit quotient, then the multiply and add. The memory read port and the
// shared divider set how long a tick runs, along with any output stall.
module linear_tween_slot_table #(
	parameter int SLOT_COUNT = lts_pkg::SLOT_COUNT_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire lts_pkg::in_item_t in_data,
	output logic                out_valid,
	input  wire                 out_stall,
	output lts_pkg::out_item_t  out_data
);
	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam int QB = 40;

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_RD   = 8'b00000010,
		S_EVAL = 8'b00000100,
		S_DIV  = 8'b00001000,
		S_MUL  = 8'b00010000,
		S_ADD  = 8'b00100000,
		S_OUT  = 8'b01000000,
		S_NEXT = 8'b10000000
	} state_t;

	state_t state_q;
	lts_pkg::in_item_t item_q;
	logic [SLOT_COUNT-1:0] valid_q, paused_q;
	logic gpause_q;
	lts_pkg::slot_t mem [SLOT_COUNT];
	lts_pkg::slot_t rd_q;
	logic [CW-1:0] idx_q;
	logic tick_q;
	logic [31:0] el_q;
	logic [QB-1:0] rem_q;
	logic [16:0] quo_q;
	logic [5:0] dcnt_q;
	logic signed [34:0] px_q, py_q;
	logic fin_q, lastc_q;
	lts_pkg::out_item_t res_q;
	logic res_v_q;

	// key search and lowest free slot over flip-flop valid bits and key copy
	logic [15:0] keys_q [SLOT_COUNT];
	logic hit;
	logic [IW-1:0] hit_idx, free_idx;
	logic any_free;
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		any_free = 1'b0;
		free_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (valid_q[i] && keys_q[i] == item_q.target_key) begin
				hit = 1'b1;
				hit_idx = IW'(i);
			end
			if (!valid_q[i]) begin
				any_free = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	// next active slot at or after idx_q for a tick
	logic nxt_found;
	logic [IW-1:0] nxt_idx;
	always_comb begin
		nxt_found = 1'b0;
		nxt_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (valid_q[i] && !paused_q[i] && CW'(i) >= idx_q) begin
				nxt_found = 1'b1;
				nxt_idx = IW'(i);
			end
		end
	end
	// is there another active slot after the current one
	logic more_after;
	always_comb begin
		more_after = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++)
			if (valid_q[i] && !paused_q[i] && CW'(i) > idx_q)
				more_after = 1'b1;
	end

	wire [IW-1:0] cur = idx_q[IW-1:0];
	assign in_stall = (state_q != S_IDLE);

	// saturating elapsed add
	logic [32:0] esum;
	assign esum = {1'b0, rd_q.elapsed} + 33'(item_q.frame_time);
	wire [31:0] enew = esum[32] ? 32'hFFFF_FFFF : esum[31:0];

	// restoring division (el << 16) / length, divisor shifted right a bit a cycle
	wire [QB-1:0] dsor = QB'(rd_q.length) << 16;

	// result register load and release
	logic res_load;
	assign res_load = (state_q == S_OUT) && (!res_v_q || !out_stall);

	// memory write port
	logic we;
	logic [IW-1:0] wa;
	lts_pkg::slot_t wd;
	always_comb begin
		we = 1'b0;
		wa = free_idx;
		wd = rd_q;
		wd.elapsed = el_q;
		if (state_q == S_RD && item_q.command == lts_pkg::CMD_START && !hit && any_free) begin
			we = 1'b1;
			wd.key = item_q.target_key;
			wd.sx = item_q.start_x;
			wd.sy = item_q.start_y;
			wd.ex = item_q.end_x;
			wd.ey = item_q.end_y;
			wd.elapsed = '0;
			wd.length = item_q.length;
		end else if (state_q == S_NEXT && tick_q) begin
			we = 1'b1;
			wa = cur;
		end
	end
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
			keys_q[wa] <= wd.key;
		end
	end
	// memory read port, address from sequencer
	logic [IW-1:0] ra;
	always_comb ra = tick_q ? nxt_idx : hit_idx;
	always_ff @(posedge clk) rd_q <= mem[ra];

	wire signed [16:0] dx = 17'(rd_q.ex) - 17'(rd_q.sx);
	wire signed [16:0] dy = 17'(rd_q.ey) - 17'(rd_q.sy);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			paused_q <= '0;
			gpause_q <= 1'b0;
			res_v_q <= 1'b0;
			tick_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (res_load) res_v_q <= 1'b1;
			else if (res_v_q && !out_stall) res_v_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) begin
					item_q <= in_data;
					idx_q <= '0;
					tick_q <= (in_data.command == lts_pkg::CMD_TICK);
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_IDLE;
					case (item_q.command)
						lts_pkg::CMD_START: if (!hit && any_free) begin
							valid_q[free_idx] <= 1'b1;
							paused_q[free_idx] <= 1'b0;
						end
						lts_pkg::CMD_TICK:
							if (!gpause_q && nxt_found) begin
								idx_q <= CW'(nxt_idx);
								state_q <= S_EVAL;
							end else tick_q <= 1'b0;
						lts_pkg::CMD_PAUSE_ONE: if (hit) paused_q[hit_idx] <= item_q.pause_value;
						lts_pkg::CMD_FREE_ONE: if (hit) begin
							idx_q <= CW'(hit_idx);
							state_q <= S_EVAL;
						end
						lts_pkg::CMD_PAUSE_ALL: gpause_q <= item_q.pause_value;
						default: ;
					endcase
				end
				S_EVAL: begin
					lastc_q <= !tick_q || !more_after;
					el_q <= enew;
					if (!tick_q || rd_q.length == '0 || enew > 32'(rd_q.length)) begin
						fin_q <= 1'b1;
						px_q <= 35'(rd_q.ex);
						py_q <= 35'(rd_q.ey);
						state_q <= S_OUT;
					end else begin
						fin_q <= 1'b0;
						rem_q <= QB'(enew) << 16;
						quo_q <= '0;
						dcnt_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// quotient fits 17 bits since el <= length
					if (rem_q >= dsor >> dcnt_q) begin
						rem_q <= rem_q - (dsor >> dcnt_q);
						quo_q <= {quo_q[15:0], 1'b1};
					end else quo_q <= {quo_q[15:0], 1'b0};
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd16) state_q <= S_MUL;
				end
				S_MUL: begin
					px_q <= dx * $signed({1'b0, quo_q});
					py_q <= dy * $signed({1'b0, quo_q});
					state_q <= S_ADD;
				end
				S_ADD: begin
					px_q <= 35'(rd_q.sx) + (px_q >>> 16);
					py_q <= 35'(rd_q.sy) + (py_q >>> 16);
					state_q <= S_OUT;
				end
				S_OUT: if (res_load) begin
					res_q.out_key <= rd_q.key;
					res_q.pos_x <= px_q[15:0];
					res_q.pos_y <= py_q[15:0];
					res_q.finished <= fin_q;
					res_q.last <= lastc_q;
					if (fin_q) begin
						valid_q[cur] <= 1'b0;
						paused_q[cur] <= 1'b0;
					end
					state_q <= tick_q ? S_NEXT : S_IDLE;
				end
				S_NEXT: begin
					idx_q <= idx_q + CW'(1);
					state_q <= S_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
	assign out_valid = res_v_q;
	assign out_data = res_q;
endmodule
`default_nettype wire

// ----- hdl/lts_checker.sv -----
// lts_checker: port-level checks for linear_tween_slot_table, and its bind
// depends on lts_pkg
`default_nettype none
module lts_checker (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_stall,
	input wire out_valid,
	input wire out_stall,
	input wire lts_pkg::out_item_t out_data
);
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	// input is not taken in the cycle right after an accept
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");
	// a result that is not finished is never the free path, so last marks end only
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.finished && !out_data.last |-> in_stall)
		else $error("block idle during a tick");
endmodule
bind linear_tween_slot_table lts_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .out_data(out_data));
`default_nettype wire

// ----- bench/tb_linear_tween_slot_table.sv -----
// tb_linear_tween_slot_table: self-checking bench for the tween slot table
// depends on lts_pkg and linear_tween_slot_table
`timescale 1ns / 100ps
`default_nettype none
module tb_linear_tween_slot_table;
	localparam int SLOTS = 16;
	localparam int STALL_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	lts_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall;
	lts_pkg::out_item_t out_data;

	linear_tween_slot_table #(.SLOT_COUNT(SLOTS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// shadow copy of the slot table
	logic        tw_valid [SLOTS];
	logic        tw_paused [SLOTS];
	logic [15:0] tw_key [SLOTS];
	logic signed [15:0] tw_sx [SLOTS];
	logic signed [15:0] tw_sy [SLOTS];
	logic signed [15:0] tw_ex [SLOTS];
	logic signed [15:0] tw_ey [SLOTS];
	logic [31:0] tw_elapsed [SLOTS];
	logic [23:0] tw_length [SLOTS];
	logic        tw_all_paused;

	lts_pkg::out_item_t pending_positions[$];
	int failures;
	int idle_phase;
	int hold_off;

	function automatic int lookup_key(logic [15:0] key);
		for (int i = 0; i < SLOTS; i++)
			if (tw_valid[i] && tw_key[i] == key)
				return i;
		return -1;
	endfunction

	// a + floor((b - a) * f / 65536), floor toward minus infinity
	function automatic logic signed [15:0] blend(logic signed [15:0] a,
			logic signed [15:0] b, logic [16:0] f);
		longint prod;
		longint q;
		prod = (longint'(b) - longint'(a)) * longint'(f);
		q = prod >>> 16;
		return 16'(longint'(a) + q);
	endfunction

	function automatic lts_pkg::out_item_t make_pos(logic [15:0] key,
			logic signed [15:0] x, logic signed [15:0] y, logic fin);
		lts_pkg::out_item_t r;
		r.out_key = key;
		r.pos_x = x;
		r.pos_y = y;
		r.finished = fin;
		r.last = 1'b0;
		return r;
	endfunction

	// advance the shadow table by one item and queue the positions it emits
	task automatic predict_positions(lts_pkg::in_item_t it);
		lts_pkg::out_item_t batch[$];
		int s;
		logic [32:0] sum;
		logic [16:0] f;
		batch = {};
		case (it.command)
			lts_pkg::CMD_START: begin
				if (lookup_key(it.target_key) < 0) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (!tw_valid[i]) begin
							tw_valid[i] = 1'b1;
							tw_paused[i] = 1'b0;
							tw_key[i] = it.target_key;
							tw_sx[i] = it.start_x;
							tw_sy[i] = it.start_y;
							tw_ex[i] = it.end_x;
							tw_ey[i] = it.end_y;
							tw_elapsed[i] = '0;
							tw_length[i] = it.length;
							break;
						end
					end
				end
			end
			lts_pkg::CMD_TICK: begin
				if (!tw_all_paused) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (tw_valid[i] && !tw_paused[i]) begin
							sum = {1'b0, tw_elapsed[i]} + 33'(it.frame_time);
							tw_elapsed[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
							if (tw_length[i] == 0 || tw_elapsed[i] > 32'(tw_length[i])) begin
								batch.push_back(make_pos(tw_key[i], tw_ex[i], tw_ey[i], 1'b1));
								tw_valid[i] = 1'b0;
								tw_paused[i] = 1'b0;
							end else begin
								f = 17'(({16'd0, tw_elapsed[i]} << 16) / 48'(tw_length[i]));
								batch.push_back(make_pos(tw_key[i],
									blend(tw_sx[i], tw_ex[i], f),
									blend(tw_sy[i], tw_ey[i], f), 1'b0));
							end
						end
					end
				end
			end
			lts_pkg::CMD_PAUSE_ONE: begin
				s = lookup_key(it.target_key);
				if (s >= 0)
					tw_paused[s] = it.pause_value;
			end
			lts_pkg::CMD_FREE_ONE: begin
				s = lookup_key(it.target_key);
				if (s >= 0) begin
					batch.push_back(make_pos(tw_key[s], tw_ex[s], tw_ey[s], 1'b1));
					tw_valid[s] = 1'b0;
					tw_paused[s] = 1'b0;
				end
			end
			lts_pkg::CMD_PAUSE_ALL: tw_all_paused = it.pause_value;
			default: ;
		endcase
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[k])
			pending_positions.push_back(batch[k]);
	endtask

	function automatic lts_pkg::in_item_t blank_item(lts_pkg::cmd_t c, logic [15:0] key);
		lts_pkg::in_item_t it;
		it = '0;
		it.command = c;
		it.target_key = key;
		return it;
	endfunction

	function automatic lts_pkg::in_item_t start_item(logic [15:0] key, logic [15:0] sx,
			logic [15:0] sy, logic [15:0] ex, logic [15:0] ey, logic [23:0] len);
		lts_pkg::in_item_t it;
		it = blank_item(lts_pkg::CMD_START, key);
		it.start_x = sx;
		it.start_y = sy;
		it.end_x = ex;
		it.end_y = ey;
		it.length = len;
		return it;
	endfunction

	function automatic lts_pkg::in_item_t tick_item(logic [19:0] ft);
		lts_pkg::in_item_t it;
		it = blank_item(lts_pkg::CMD_TICK, 16'd0);
		it.frame_time = ft;
		return it;
	endfunction

	function automatic lts_pkg::in_item_t pause_item(lts_pkg::cmd_t c, logic [15:0] key,
			logic pv);
		lts_pkg::in_item_t it;
		it = blank_item(c, key);
		it.pause_value = pv;
		return it;
	endfunction

	// random item, mostly useful commands over a small key pool
	function automatic lts_pkg::in_item_t random_item();
		lts_pkg::in_item_t it;
		int pick;
		it = lts_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
		it.target_key = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			it.command = lts_pkg::CMD_START;
			if ($urandom_range(0, 2) != 0)
				it.length = 24'($urandom_range(0, 5000));
		end else if (pick < 75) begin
			it.command = lts_pkg::CMD_TICK;
			if ($urandom_range(0, 3) != 0)
				it.frame_time = 20'($urandom_range(0, 1200));
		end else if (pick < 85) begin
			it.command = lts_pkg::CMD_PAUSE_ONE;
		end else if (pick < 93) begin
			it.command = lts_pkg::CMD_FREE_ONE;
		end else if (pick < 97) begin
			it.command = lts_pkg::CMD_PAUSE_ALL;
			it.pause_value = ($urandom_range(0, 2) == 0);
		end else begin
			it.command = 3'($urandom_range(5, 7));
		end
		return it;
	endfunction

	// send one item, with idling per phase; valid stays up until the next idle
	task automatic send_item(lts_pkg::in_item_t it);
		while ((idle_phase == 1 || idle_phase == 3) &&
				$urandom_range(0, 99) < ((idle_phase == 1) ? 51 : 14)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_positions(it);
	endtask

	// receiver stall, random per phase plus one long hold-off
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else if (idle_phase == 2)
			out_stall <= ($urandom_range(0, 99) < 51);
		else if (idle_phase == 3)
			out_stall <= ($urandom_range(0, 99) < 14);
		else
			out_stall <= 1'b0;
	end

	// compare each result with the oldest expected one
	always @(posedge clk) begin
		lts_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_positions.size() == 0) begin
				$error("unexpected result key %h", out_data.out_key);
				failures++;
			end else begin
				want = pending_positions.pop_front();
				if (out_data.out_key !== want.out_key) begin
					$error("out_key expected %h got %h", want.out_key, out_data.out_key);
					failures++;
				end
				if (out_data.pos_x !== want.pos_x) begin
					$error("pos_x expected %h got %h", want.pos_x, out_data.pos_x);
					failures++;
				end
				if (out_data.pos_y !== want.pos_y) begin
					$error("pos_y expected %h got %h", want.pos_y, out_data.pos_y);
					failures++;
				end
				if (out_data.finished !== want.finished) begin
					$error("finished expected %b got %b", want.finished, out_data.finished);
					failures++;
				end
				if (out_data.last !== want.last) begin
					$error("last expected %b got %b", want.last, out_data.last);
					failures++;
				end
			end
		end
	end

	// watchdog on cycles in which no item is accepted and no result is taken
	int quiet_cycles;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// directed rows; the expectation is typed in where it is plain
	typedef struct {
		lts_pkg::in_item_t  stim;
		logic               typed;
		lts_pkg::out_item_t want;
	} directed_row_t;

	directed_row_t plan[$];

	task automatic add_row(lts_pkg::in_item_t it);
		directed_row_t r;
		r.stim = it;
		r.typed = 1'b0;
		r.want = '0;
		plan.push_back(r);
	endtask

	task automatic add_typed(lts_pkg::in_item_t it, lts_pkg::out_item_t w);
		directed_row_t r;
		r.stim = it;
		r.typed = 1'b1;
		r.want = w;
		plan.push_back(r);
	endtask

	initial begin
		int drain;
		lts_pkg::out_item_t w;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		failures = 0;
		idle_phase = 0;
		hold_off = 0;
		quiet_cycles = 0;
		for (int i = 0; i < SLOTS; i++) begin
			tw_valid[i] = 1'b0;
			tw_paused[i] = 1'b0;
			tw_key[i] = '0;
			tw_sx[i] = '0;
			tw_sy[i] = '0;
			tw_ex[i] = '0;
			tw_ey[i] = '0;
			tw_elapsed[i] = '0;
			tw_length[i] = '0;
		end
		tw_all_paused = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: tick on empty table, extremes, zero duration, duplicates
		add_row(tick_item(20'hFFFFF));
		add_row(blank_item(lts_pkg::CMD_FREE_ONE, 16'h1234));
		add_row(start_item(16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 24'hFFFFFF));
		add_row(start_item(16'h0000, 16'h0000, 16'h0000, 16'h0010, 16'h0010, 24'd5));
		add_row(start_item(16'hFFFF, 16'h0010, 16'hFFF0, 16'h0020, 16'hFFE0, 24'd0));
		add_row(start_item(16'h0002, 16'h0000, 16'h0000, 16'h0064, 16'hFF9C, 24'd100));
		add_row(tick_item(20'd40));
		add_row(pause_item(lts_pkg::CMD_PAUSE_ONE, 16'h0002, 1'b1));
		add_row(tick_item(20'd40));
		add_row(pause_item(lts_pkg::CMD_PAUSE_ALL, 16'h0000, 1'b1));
		add_row(tick_item(20'd40));
		add_row(pause_item(lts_pkg::CMD_PAUSE_ALL, 16'h0000, 1'b0));
		add_row(pause_item(lts_pkg::CMD_PAUSE_ONE, 16'h0002, 1'b0));
		add_row(pause_item(lts_pkg::CMD_PAUSE_ONE, 16'h7777, 1'b1));
		add_row(tick_item(20'd60));
		add_row(tick_item(20'd1));
		w = make_pos(16'h0000, 16'h7FFF, 16'h8000, 1'b1);
		w.last = 1'b1;
		add_typed(blank_item(lts_pkg::CMD_FREE_ONE, 16'h0000), w);
		add_row(blank_item(lts_pkg::cmd_t'(3'd5), 16'h0001));
		add_row(blank_item(lts_pkg::cmd_t'(3'd7), 16'h0001));
		for (int i = 0; i < 17; i++)
			add_row(start_item(16'(16'h100 + i), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 24'(i * 300)));
		// long frame times finish the whole table at once
		add_row(tick_item(20'hFFFFF));
		add_row(tick_item(20'hFFFFF));

		foreach (plan[r]) begin
			if (plan[r].typed)
				pending_positions.push_back(plan[r].want);
			send_item(plan[r].stim);
			// typed row repeats the same result; drop the predictor copy
			if (plan[r].typed)
				void'(pending_positions.pop_back());
		end

		// random part through the idling phases
		for (int n = 0; n < 410; n++) begin
			idle_phase = (n / 80) % 4;
			if (n == 200)
				hold_off = 3000;
			send_item(random_item());
		end
		in_valid <= 1'b0;
		idle_phase = 0;

		drain = 0;
		while (pending_positions.size() > 0 && drain < 400000) begin
			@(posedge clk);
			drain++;
		end
		repeat (1000) @(posedge clk);
		if (failures == 0 && pending_positions.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire
